FILE: rtl/lls_pkg.sv
package lls_pkg;

    localparam int MAX_LEN = 1024;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int VAL_W   = 32;
    localparam int LIS_W   = 11;

    localparam logic REQ_PUSH   = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    typedef struct packed {
        logic                    finish;
        logic signed [VAL_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic [LIS_W-1:0] lis_length;
        logic             overflow;
    } t_res;

endpackage

FILE: rtl/lls_front.sv
module lls_front
    import lls_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    output logic                    o_full,
    input  logic                    i_req_type,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_cmd_valid,
    output t_cmd                    o_cmd,
    input  logic                    i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_wr;
    logic       w_rd;
    t_cmd       w_in;

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_wr        = i_push && !o_full;
    assign w_rd        = i_cmd_pop && o_cmd_valid;

    // Classify: finish or push; value only matters for a push.
    always_comb begin
        w_in.finish = (i_req_type == REQ_FINISH);
        w_in.value  = i_value;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= w_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            unique case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: rtl/lls_res_q.sv
module lls_res_q
    import lls_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_res i_res,
    output logic o_full,
    output logic o_empty,
    output t_res o_res,
    input  logic i_pop
);

    t_res       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_wr;
    logic       w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_res   = r_q[r_rp];
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            unique case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: rtl/lls_back.sv
module lls_back
    import lls_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    input  logic i_res_full,
    output logic o_res_wr,
    output t_res o_res
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SRCH = 1'b1;

    logic [VAL_W-1:0]        r_mem [MAX_LEN];
    logic signed [VAL_W-1:0] r_rdata;

    logic                    r_state, n_state;
    logic [LEN_W-1:0]        r_len, n_len;
    logic                    r_ovf, n_ovf;
    logic signed [VAL_W-1:0] r_last, n_last;
    logic signed [VAL_W-1:0] r_val, n_val;
    logic [LEN_W-1:0]        r_lo, n_lo;
    logic [LEN_W-1:0]        r_hi, n_hi;
    logic [ADDR_W-1:0]       r_mid, n_mid;

    logic                    w_we;
    logic [ADDR_W-1:0]       w_waddr;
    logic signed [VAL_W-1:0] w_wdata;
    logic [ADDR_W-1:0]       w_raddr;
    logic [LEN_W-1:0]        w_slo;
    logic [LEN_W-1:0]        w_shi;
    logic [LEN_W:0]          w_sum;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_ovf     = r_ovf;
        n_last    = r_last;
        n_val     = r_val;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        w_we      = 1'b0;
        w_waddr   = r_len[ADDR_W-1:0];
        w_wdata   = i_cmd.value;
        w_raddr   = r_mid;
        o_cmd_pop = 1'b0;
        o_res_wr  = 1'b0;
        o_res.lis_length = LIS_W'(r_len);
        o_res.overflow   = r_ovf;
        w_slo     = r_lo;
        w_shi     = r_hi;
        w_sum     = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.finish) begin
                        // Report and start a new sequence once there is room.
                        if (!i_res_full) begin
                            o_res_wr  = 1'b1;
                            o_cmd_pop = 1'b1;
                            n_len     = '0;
                            n_ovf     = 1'b0;
                        end
                    end else if (r_len == '0 || i_cmd.value > r_last) begin
                        o_cmd_pop = 1'b1;
                        if (r_len < LEN_W'(MAX_LEN)) begin
                            w_we   = 1'b1;
                            n_last = i_cmd.value;
                            n_len  = r_len + LEN_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else begin
                        // Overwrite: binary search over [0, len).
                        o_cmd_pop = 1'b1;
                        n_val     = i_cmd.value;
                        n_lo      = '0;
                        n_hi      = r_len;
                        n_mid     = ADDR_W'(r_len >> 1);
                        w_raddr   = n_mid;
                        n_state   = ST_SRCH;
                    end
                end
            end
            ST_SRCH: begin
                if (r_rdata < r_val) begin
                    w_slo = LEN_W'(r_mid) + LEN_W'(1);
                end else begin
                    w_shi = LEN_W'(r_mid);
                end
                n_lo  = w_slo;
                n_hi  = w_shi;
                w_sum = {1'b0, w_slo} + {1'b0, w_shi};
                if (w_slo < w_shi) begin
                    n_mid   = ADDR_W'(w_sum >> 1);
                    w_raddr = n_mid;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = w_slo[ADDR_W-1:0];
                    w_wdata = r_val;
                    if (w_slo == r_len - LEN_W'(1)) begin
                        n_last = r_val;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_len   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_ovf   <= n_ovf;
        end
        r_last <= n_last;
        r_val  <= n_val;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mid  <= n_mid;
    end

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(MAX_LEN))
        else $error("tails length beyond store depth");

    a_srch_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SRCH) |-> (r_lo < r_hi && r_hi <= r_len))
        else $error("search window empty or beyond length");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovf) |-> (r_len == LEN_W'(MAX_LEN)))
        else $error("overflow raised below full length");

    a_srch_len_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SRCH) |=> (r_len == $past(r_len)))
        else $error("length changed during search");

endmodule

FILE: rtl/lis_length_tails_search.sv
// Longest strictly increasing subsequence length over a stream of signed
// 32-bit values, patience method. Push an item with req_type 0 to add an
// element, and an item with req_type 1 to finish the sequence: the finish
// yields one result holding the length (0 for an empty sequence) and an
// overflow flag set if an append was dropped because 1024 tails were
// already held; the length and flag then clear. Pushes produce no result.
// Items pass through a two-entry input queue to the search engine, and
// results wait in a two-entry output queue, so a result may sit unpopped
// while new items keep flowing. An element that appends (greater than the
// last tail) and a finish need no search. An element that replaces a tail
// runs a binary search with one tails-memory read per binary-search step,
// the write-back folded into the last step; no new item is taken until the
// search ends. No clearing pass is needed after reset.
module lis_length_tails_search
    import lls_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic                    i_req_type,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    empty,
    input  logic                    pop,
    output logic [LIS_W-1:0]        o_lis_length,
    output logic                    o_overflow
);

    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_cmd_pop;
    logic w_res_full;
    logic w_res_wr;
    t_res w_res;
    t_res w_res_out;

    // Accept and classify incoming items.
    lls_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_req_type  (i_req_type),
        .i_value     (i_value),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    // Append, binary-search and overwrite tails; report on finish.
    lls_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_full  (w_res_full),
        .o_res_wr    (w_res_wr),
        .o_res       (w_res)
    );

    // Hold results until the consumer pops them.
    lls_res_q u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_res_wr),
        .i_res   (w_res),
        .o_full  (w_res_full),
        .o_empty (empty),
        .o_res   (w_res_out),
        .i_pop   (pop)
    );

    assign o_lis_length = w_res_out.lis_length;
    assign o_overflow   = w_res_out.overflow;

endmodule

FILE: sim/lls_checker.sv
module lls_checker
    import lls_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic                    i_full,
    input  logic                    i_req_type,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_empty,
    input  logic                    i_pop,
    input  logic [LIS_W-1:0]        i_lis_length,
    input  logic                    i_overflow,
    output int                      o_fail_count,
    output int                      o_pending_cnt
);

    // tails[k] holds the smallest value ending an increasing run of length k+1
    logic signed [VAL_W-1:0] tails [MAX_LEN];
    int unsigned             run_len;
    logic                    run_dropped;
    t_res                    lengths_owed [$];
    int                      fail_cnt = 0;

    assign o_fail_count = fail_cnt;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        fail_cnt++;
    endtask

    function automatic void absorb_element(input logic signed [VAL_W-1:0] v);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        if (run_len == 0 || v > tails[run_len - 1]) begin
            if (run_len < MAX_LEN) begin
                tails[run_len] = v;
                run_len++;
            end else begin
                run_dropped = 1'b1;
            end
        end else begin
            lo = 0;
            hi = run_len;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (tails[mid] < v) lo = mid + 1;
                else hi = mid;
            end
            tails[lo] = v;
        end
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            run_len     = 0;
            run_dropped = 1'b0;
            lengths_owed.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (lengths_owed.size() == 0) begin
                    report_mismatch($sformatf("unexpected result length=%0d overflow=%0b",
                                              i_lis_length, i_overflow));
                end else begin
                    want = lengths_owed.pop_front();
                    if (i_lis_length !== want.lis_length)
                        report_mismatch($sformatf("lis_length %0d, want %0d",
                                                  i_lis_length, want.lis_length));
                    if (i_overflow !== want.overflow)
                        report_mismatch($sformatf("overflow %0b, want %0b",
                                                  i_overflow, want.overflow));
                end
            end
            if (i_push && !i_full) begin
                if (i_req_type == REQ_FINISH) begin
                    want.lis_length = LIS_W'(run_len);
                    want.overflow   = run_dropped;
                    lengths_owed.insert(lengths_owed.size(), want);
                    run_len     = 0;
                    run_dropped = 1'b0;
                end else begin
                    absorb_element(i_value);
                end
            end
        end
        o_pending_cnt <= lengths_owed.size();
    end

endmodule

FILE: sim/tb.sv
module tb;
    import lls_pkg::*;

    // Generous ceiling: ~4k items at worst-case search depth, gaps and stalls
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 700;
    localparam int DRAIN_CYCLES = 40;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    push;
    logic                    full;
    logic                    i_req_type;
    logic signed [VAL_W-1:0] i_value;
    logic                    empty;
    logic                    pop;
    logic [LIS_W-1:0]        o_lis_length;
    logic                    o_overflow;

    int  fail_cnt;
    int  pending_cnt;
    int  cycle_cnt;
    int  items_sent;

    // Shared knobs between the sender and the receiver process
    logic tx_steady = 1'b0;  // sender never idles while set
    logic rx_steady = 1'b0;  // receiver never idles while set
    logic hold_req  = 1'b0;  // ask the receiver for one long hold-off

    longint drift_val;       // running level for mostly-increasing runs

    lis_length_tails_search uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_req_type   (i_req_type),
        .i_value      (i_value),
        .empty        (empty),
        .pop          (pop),
        .o_lis_length (o_lis_length),
        .o_overflow   (o_overflow)
    );

    lls_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_req_type    (i_req_type),
        .i_value       (i_value),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_lis_length  (o_lis_length),
        .i_overflow    (o_overflow),
        .o_fail_count  (fail_cnt),
        .o_pending_cnt (pending_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: stop a hung run
    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt >= CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_cnt);
                $display("FAIL lis_length_tails_search");
                $finish;
            end
        end
    end

    // Receiver: pop at random, hold off for a long stretch when asked
    initial begin
        pop = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                pop <= rx_steady || ($urandom_range(0, 99) >= 29);
            end
        end
    end

    // Offer one item, idling at random first; return once it is accepted.
    // Leave push high afterwards so back-to-back items need no extra edge.
    task automatic send_item(input logic req, input logic signed [VAL_W-1:0] val);
        while (!tx_steady && $urandom_range(0, 99) < 29) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push       <= 1'b1;
        i_req_type <= req;
        i_value    <= val;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_element(input logic signed [VAL_W-1:0] val);
        send_item(REQ_PUSH, val);
    endtask

    // Finish carries a random value: the block must ignore it
    task automatic send_finish();
        send_item(REQ_FINISH, $urandom());
    endtask

    // Push n strictly increasing values from a random low start; with
    // n above MAX_LEN the tail of the run hits the full store.
    task automatic send_rising_run(input int n);
        longint lvl;
        lvl = -64'sd2147483648 + $urandom_range(0, 1000);
        for (int k = 0; k < n; k++) begin
            send_element(VAL_W'(lvl));
            lvl += $urandom_range(1, 1 << 21);
        end
    endtask

    // Pick an element: full range, a narrow band full of repeats, or a drift
    function automatic logic signed [VAL_W-1:0] pick_element(input int flavor);
        case (flavor)
            0: pick_element = $urandom();
            1: pick_element = $signed($urandom_range(0, 16)) - 8;
            default: begin
                drift_val += $signed($urandom_range(0, 60)) - 15;
                pick_element = VAL_W'(drift_val);
            end
        endcase
    endfunction

    initial begin
        int flavor;
        int run_n;
        int random_done;

        i_rst_n    = 1'b0;
        push       = 1'b0;
        i_req_type = REQ_PUSH;
        i_value    = '0;
        items_sent = 0;
        drift_val  = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty sequence first
        send_finish();

        // Extremes, replacement at the front, equal values, append after replace
        send_element(VAL_MIN);
        send_element(VAL_MAX);
        send_element(VAL_MIN);
        send_element(32'sd0);
        send_element(32'sd0);
        send_element(32'sd1);
        send_element(-32'sd1);
        send_element(VAL_MAX);
        send_element(VAL_MAX);
        send_finish();

        // Strictly decreasing run: length one
        send_element(32'sd10);
        send_element(32'sd9);
        send_element(32'sd8);
        send_element(-32'sd7);
        send_finish();

        // Finish right after finish: empty again
        send_finish();

        // Fill the store exactly, no overflow
        rx_steady = 1'b1;
        send_rising_run(MAX_LEN);
        send_finish();

        // Overrun the store, then replace inside it and overrun once more
        send_rising_run(MAX_LEN + 3);
        send_element(VAL_MIN);
        send_element(32'sd0);
        send_element($urandom());
        send_element(VAL_MAX);
        send_finish();
        // Overflow flag must be cleared by that finish
        send_finish();
        rx_steady = 1'b0;

        // Back-pressure: receiver stalls while short sequences keep coming
        hold_req = 1'b1;
        for (int s = 0; s < 30; s++) begin
            run_n = $urandom_range(0, 3);
            for (int k = 0; k < run_n; k++) send_element($urandom());
            send_finish();
        end

        // Random sequences; a stretch in the middle runs with no idling
        random_done = 0;
        while (random_done < RANDOM_ITEMS) begin
            tx_steady = (random_done > 250 && random_done < 400);
            rx_steady = tx_steady;
            flavor    = $urandom_range(0, 2);
            drift_val = $signed($urandom());
            run_n     = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200)
                                                    : $urandom_range(0, 25);
            for (int k = 0; k < run_n; k++) begin
                // Occasionally inject noise into a drifting run
                if (flavor == 2 && $urandom_range(0, 9) == 0)
                    send_element($urandom());
                else
                    send_element(pick_element(flavor));
            end
            send_finish();
            random_done += run_n + 1;
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        // Release push, let the checker register the last finish, then drain
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_cnt == 0) begin
            $display("PASS lis_length_tails_search");
        end else begin
            $display("FAIL lis_length_tails_search");
        end
        $finish;
    end

endmodule
